### src/assert_macros.svh
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PSDM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define PSDM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/psdm_pkg.sv
package psdm_pkg;

    localparam int NUM_NOTES  = 13;
    localparam int TABLE_SIZE = 8191;
    localparam int MAX_DUTY   = 1023;

    // fixed field widths
    localparam int FUNC_W = 1;
    localparam int MASK_W = 13;
    localparam int SEL_W  = 4;
    localparam int INC_W  = 13;
    localparam int DUTY_W = 16;
    localparam int ACNT_W = 4;

    localparam int PHASE_W    = $clog2(TABLE_SIZE);
    localparam int ADV_W      = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
    localparam int VOICE_W    = (NUM_NOTES > 1) ? $clog2(NUM_NOTES) : 1;
    localparam int CNT_W      = $clog2(NUM_NOTES + 1);
    localparam int SUM_W      = $clog2(NUM_NOTES * MAX_DUTY + 1);
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic scan;
        logic drain;
        logic div_start;
        logic emit;
    } ctrl_t;

    // Q62 fixed point for the table build
    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_HALF_PI = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    // (a * b) >> 62, truncated to 64 bits
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // sin(pi/2 * m / TABLE_SIZE) in Q62
    function automatic logic [63:0] quarter_sine(input logic [63:0] m);
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] frac;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] acc;
        if (m == 64'd0) return 64'd0;
        if (m >= 64'(TABLE_SIZE)) return Q62_ONE;
        if ((m * 64'd3) == 64'(TABLE_SIZE)) return Q62_ONE >> 1;
        q1    = (m << 40) / 64'(TABLE_SIZE);
        r1    = (m << 40) % 64'(TABLE_SIZE);
        frac  = (q1 << 22) + ((r1 << 22) / 64'(TABLE_SIZE));
        theta = mul_q62(frac, Q62_HALF_PI);
        t2    = mul_q62(theta, theta);
        term  = theta;
        acc   = theta;
        for (int k = 0; k < 12; k++)
        begin
            term = mul_q62(term, t2) / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return (acc > Q62_ONE) ? Q62_ONE : acc;
    endfunction

    // floor((sin(2*pi*i/N) + 1) / 2 * MAX_DUTY)
    function automatic logic [DUTY_W-1:0] rom_entry(input int i);
        logic [63:0]  q;
        logic [63:0]  quad;
        logic [63:0]  r;
        logic [63:0]  m;
        logic [63:0]  s;
        logic [63:0]  u;
        logic [127:0] p;
        q    = 64'(i) * 64'd4;
        quad = (q / 64'(TABLE_SIZE)) & 64'd3;
        r    = q % 64'(TABLE_SIZE);
        m    = quad[0] ? (64'(TABLE_SIZE) - r) : r;
        s    = quarter_sine(m);
        u    = (quad < 64'd2) ? (Q62_ONE + s) : (Q62_ONE - s);
        p    = 128'(MAX_DUTY) * {64'd0, u};
        return p[63+DUTY_W-1:63];
    endfunction

endpackage

### src/polyphonic_sine_dds_mixer_core.sv
// Polyphonic sine DDS mixer.
// Input channel (in_valid/in_ready) carries func, note_mask, note_select and
// increment. A load transaction (func = load) sets one voice's phase step and
// produces nothing. A tick transaction reads the sine ROM for every voice
// in turn, one voice per cycle, advancing each voice's phase, then
// divides the sum of the masked samples by their count with a bit-serial
// divider. Output channel (out_valid/out_ready) carries duty and active_count.
// A tick's result becomes valid in the same cycle that in_ready returns, so
// a tick runs through scan, drain and divide before the next input is taken;
// a load leaves in_ready high.
// The voice scan over the single ROM read port and the divider set the length of a tick.
// The result sits in an output register: further inputs are taken while it
// waits, but a following tick holds at its end until the register is free.
// Reset clears all phases and steps to zero and drops out_valid.
`include "assert_macros.svh"

module polyphonic_sine_dds_mixer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [psdm_pkg::FUNC_W-1:0] func,
    input  logic [psdm_pkg::MASK_W-1:0] note_mask,
    input  logic [psdm_pkg::SEL_W-1:0]  note_select,
    input  logic [psdm_pkg::INC_W-1:0]  increment,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [psdm_pkg::DUTY_W-1:0] duty,
    output logic [psdm_pkg::ACNT_W-1:0] active_count
);

    psdm_pkg::state_t state_reg;
    psdm_pkg::state_t state_next;
    psdm_pkg::ctrl_t  ctrl;

    logic [psdm_pkg::PHASE_W-1:0] phase_index_reg [psdm_pkg::NUM_NOTES];
    logic [psdm_pkg::INC_W-1:0]   phase_step_reg  [psdm_pkg::NUM_NOTES];

    logic [psdm_pkg::VOICE_W-1:0] voice_reg;
    logic [psdm_pkg::MASK_W-1:0]  mask_reg;
    logic                         take_reg;
    logic [psdm_pkg::SUM_W-1:0]   sum_reg;
    logic [psdm_pkg::CNT_W-1:0]   count_reg;

    logic                         out_valid_reg;
    logic [psdm_pkg::DUTY_W-1:0]  duty_reg;
    logic [psdm_pkg::ACNT_W-1:0]  active_count_reg;

    logic                         tick_acc;
    logic                         load_acc;
    logic                         voice_last;
    logic                         out_free;
    logic                         take;
    logic [psdm_pkg::MASK_W-1:0]  mask_shift;
    logic [psdm_pkg::ADV_W-1:0]   adv;
    logic [psdm_pkg::SUM_W-1:0]   sum_next;
    logic [psdm_pkg::PHASE_W-1:0] rom_addr;
    logic [psdm_pkg::DUTY_W-1:0]  rom_data;
    logic [psdm_pkg::SUM_W-1:0]   quotient;
    logic                         div_done;

    assign tick_acc   = in_valid && ctrl.in_ready && (func == psdm_pkg::FUNC_TICK);
    assign load_acc   = in_valid && ctrl.in_ready && (func == psdm_pkg::FUNC_LOAD);
    assign voice_last = (voice_reg == psdm_pkg::VOICE_W'(psdm_pkg::NUM_NOTES - 1));
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        rom_addr   = phase_index_reg[voice_reg];
        adv        = psdm_pkg::ADV_W'(phase_index_reg[voice_reg])
                   + psdm_pkg::ADV_W'(phase_step_reg[voice_reg]);
        mask_shift = mask_reg >> voice_reg;
        take       = (32'(voice_reg) < 32'(psdm_pkg::MASK_W)) && mask_shift[0];
        // sample of the voice issued in the previous cycle
        sum_next   = take_reg ? (sum_reg + psdm_pkg::SUM_W'(rom_data)) : sum_reg;
    end

    psdm_sine_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    psdm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (sum_next),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psdm_pkg::ST_IDLE:
                if (tick_acc) state_next = psdm_pkg::ST_SCAN;
            psdm_pkg::ST_SCAN:
                if (voice_last) state_next = psdm_pkg::ST_DRAIN;
            psdm_pkg::ST_DRAIN:
                state_next = psdm_pkg::ST_DIV;
            psdm_pkg::ST_DIV:
                if (div_done) state_next = psdm_pkg::ST_DONE;
            psdm_pkg::ST_DONE:
                if (out_free) state_next = psdm_pkg::ST_IDLE;
            default:
                state_next = psdm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            psdm_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
            psdm_pkg::ST_SCAN:  ctrl.scan = 1'b1;
            psdm_pkg::ST_DRAIN:
            begin
                ctrl.drain     = 1'b1;
                ctrl.div_start = 1'b1;
            end
            psdm_pkg::ST_DIV:   ctrl = '0;
            psdm_pkg::ST_DONE:  ctrl.emit = out_free;
            default:            ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= psdm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < psdm_pkg::NUM_NOTES; n++)
            begin
                phase_index_reg[n] <= '0;
                phase_step_reg[n]  <= '0;
            end
        end
        else
        begin
            if (load_acc && (32'(note_select) < 32'(psdm_pkg::NUM_NOTES)))
                phase_step_reg[note_select[psdm_pkg::VOICE_W-1:0]] <= increment;
            // reaching the table size restarts at zero rather than wrapping
            if (ctrl.scan)
                phase_index_reg[voice_reg] <= (adv >= psdm_pkg::ADV_W'(psdm_pkg::TABLE_SIZE))
                                            ? '0 : adv[psdm_pkg::PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_reg <= '0;
            mask_reg  <= '0;
            take_reg  <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (tick_acc)
        begin
            voice_reg <= '0;
            mask_reg  <= note_mask;
            take_reg  <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (ctrl.scan)
        begin
            // stays on the last voice so the index never leaves the array
            voice_reg <= voice_last ? voice_reg : voice_reg + 1'b1;
            take_reg  <= take;
            sum_reg   <= sum_next;
            count_reg <= count_reg + psdm_pkg::CNT_W'(take);
        end
        else if (ctrl.drain)
        begin
            take_reg <= 1'b0;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            duty_reg         <= (count_reg == '0) ? '0 : psdm_pkg::DUTY_W'(quotient);
            active_count_reg <= psdm_pkg::ACNT_W'(count_reg);
        end
    end

    assign in_ready     = ctrl.in_ready;
    assign out_valid    = out_valid_reg;
    assign duty         = duty_reg;
    assign active_count = active_count_reg;

    `PSDM_ASSERT_NXT(a_done_holds, clk, rst_n,
        (state_reg == psdm_pkg::ST_DONE) && out_valid_reg && !out_ready,
        state_reg == psdm_pkg::ST_DONE)
    `PSDM_ASSERT_IMP(a_silent_zero, clk, rst_n,
        out_valid_reg && (active_count_reg == '0), duty_reg == '0)
    `PSDM_ASSERT_IMP(a_duty_range, clk, rst_n,
        out_valid_reg, 32'(duty_reg) <= 32'(psdm_pkg::MAX_DUTY))
    `PSDM_ASSERT_NXT(a_scan_start, clk, rst_n,
        tick_acc, (state_reg == psdm_pkg::ST_SCAN) && (voice_reg == '0))

endmodule

### src/psdm_sine_rom.sv
module psdm_sine_rom (
    input  logic                         clk,
    input  logic [psdm_pkg::PHASE_W-1:0] addr,
    output logic [psdm_pkg::DUTY_W-1:0]  data
);

    logic [psdm_pkg::DUTY_W-1:0] rom_w [psdm_pkg::TABLE_SIZE];
    logic [psdm_pkg::DUTY_W-1:0] data_reg;

    for (genvar g = 0; g < psdm_pkg::TABLE_SIZE; g++)
    begin : g_entry
        localparam logic [psdm_pkg::DUTY_W-1:0] ENTRY = psdm_pkg::rom_entry(g);
        assign rom_w[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_w[addr];
    end

    assign data = data_reg;

endmodule

### src/psdm_divider.sv
// Restoring divider, one quotient bit per cycle.
module psdm_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [psdm_pkg::SUM_W-1:0] dividend,
    input  logic [psdm_pkg::CNT_W-1:0] divisor,
    output logic [psdm_pkg::SUM_W-1:0] quotient,
    output logic                       done
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [psdm_pkg::DIV_STEP_W-1:0] step_reg;
    logic [psdm_pkg::SUM_W-1:0]      quo_reg;
    logic [psdm_pkg::CNT_W-1:0]      rem_reg;
    logic [psdm_pkg::CNT_W-1:0]      dsr_reg;

    logic [psdm_pkg::CNT_W:0]   shifted;
    logic [psdm_pkg::CNT_W:0]   diff;
    logic                       ge;
    logic [psdm_pkg::CNT_W-1:0] rem_next;
    logic [psdm_pkg::SUM_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[psdm_pkg::SUM_W-1]};
        ge       = (shifted >= {1'b0, dsr_reg});
        diff     = shifted - {1'b0, dsr_reg};
        // remainder stays below the divisor, so the top bit is always clear
        rem_next = ge ? diff[psdm_pkg::CNT_W-1:0] : shifted[psdm_pkg::CNT_W-1:0];
        quo_next = (quo_reg << 1) | psdm_pkg::SUM_W'(ge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == psdm_pkg::DIV_STEP_W'(psdm_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### verif/testbench.sv
module testbench;
    import psdm_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_ITEMS    = 560;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [ACNT_W-1:0] active;
    } mix_result_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY
    } rx_mode_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [FUNC_W-1:0]   func;
    logic [MASK_W-1:0]   note_mask;
    logic [SEL_W-1:0]    note_select;
    logic [INC_W-1:0]    increment;
    logic                out_valid;
    logic                out_ready;
    logic [DUTY_W-1:0]   duty;
    logic [ACNT_W-1:0]   active_count;

    // predictor state
    logic [DUTY_W-1:0]   sine_table [TABLE_SIZE];
    logic [PHASE_W-1:0]  voice_phase [NUM_NOTES];
    logic [INC_W-1:0]    voice_step [NUM_NOTES];
    mix_result_t         expected_mix [$];
    mix_result_t         mix_seen;

    int                  errors;
    int                  idle_cycles;
    int                  burst_left;
    int                  stall_left;
    rx_mode_t            rx_mode;
    bit                  gaps_on;
    bit                  hold_off_req;

    polyphonic_sine_dds_mixer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .note_mask    (note_mask),
        .note_select  (note_select),
        .increment    (increment),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .duty         (duty),
        .active_count (active_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // sine table, built the same way as the hardware table: quadrant
    // folding, Q62 angle, Taylor series with truncating products
    // ---------------------------------------------------------------
    function automatic logic [63:0] product_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[125:62];
    endfunction

    function automatic logic [63:0] quarter_wave_q62(input logic [63:0] m);
        logic [63:0] span;
        logic [63:0] whole;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] theta;
        logic [63:0] theta_sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] divisor;
        span = 64'(TABLE_SIZE);
        if (m == 64'd0)
            return 64'd0;
        if (m >= span)
            return Q62_ONE;
        if (m * 64'd3 == span)
            return Q62_ONE >> 1;
        whole    = (m << 40) / span;
        rem      = (m << 40) % span;
        frac     = (whole << 22) + ((rem << 22) / span);
        theta    = product_q62(frac, Q62_HALF_PI);
        theta_sq = product_q62(theta, theta);
        term     = theta;
        acc      = theta;
        for (int k = 1; k <= 12; k++)
        begin
            divisor = 64'(4 * k * k + 2 * k);
            term    = product_q62(term, theta_sq) / divisor;
            acc     = (k % 2 == 1) ? acc - term : acc + term;
        end
        return (acc > Q62_ONE) ? Q62_ONE : acc;
    endfunction

    function automatic logic [DUTY_W-1:0] sine_table_entry(input int i);
        logic [63:0]  span;
        logic [63:0]  q;
        logic [63:0]  quad;
        logic [63:0]  r;
        logic [63:0]  m;
        logic [63:0]  s;
        logic [63:0]  level;
        logic [127:0] scaled;
        span   = 64'(TABLE_SIZE);
        q      = 64'(i) * 64'd4;
        quad   = (q / span) & 64'd3;
        r      = q % span;
        m      = quad[0] ? span - r : r;
        s      = quarter_wave_q62(m);
        level  = (quad < 64'd2) ? Q62_ONE + s : Q62_ONE - s;
        scaled = 128'(MAX_DUTY) * 128'(level);
        return scaled[63 +: DUTY_W];
    endfunction

    // ---------------------------------------------------------------
    // predictor: applies one accepted transaction to the voice state
    // ---------------------------------------------------------------
    task automatic apply_voice_item(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] mask,
                                    input logic [SEL_W-1:0] sel, input logic [INC_W-1:0] inc);
        logic [31:0]      total;
        int               voices;
        logic [PHASE_W:0] advanced;
        mix_result_t      res;
        if (f == FUNC_LOAD)
        begin
            if (sel < NUM_NOTES)
                voice_step[sel] = inc;
            return;
        end
        total  = '0;
        voices = 0;
        for (int n = 0; n < NUM_NOTES; n++)
        begin
            if (mask[n])
            begin
                total  = total + 32'(sine_table[voice_phase[n]]);
                voices = voices + 1;
            end
            // every voice moves on, sounding or not; no modulo wrap
            advanced = {1'b0, voice_phase[n]} + {1'b0, voice_step[n]};
            voice_phase[n] = (advanced >= TABLE_SIZE) ? '0 : advanced[PHASE_W-1:0];
        end
        res.duty   = (voices > 0) ? DUTY_W'(total / 32'(voices)) : '0;
        res.active = ACNT_W'(voices);
        expected_mix.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // sender: bursts with random gaps, valid held until accepted
    // ---------------------------------------------------------------
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] mask,
                             input logic [SEL_W-1:0] sel, input logic [INC_W-1:0] inc);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        func        <= f;
        note_mask   <= mask;
        note_select <= sel;
        increment   <= inc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_voice_item(f, mask, sel, inc);
        if (burst_left > 0)
            burst_left--;
    endtask

    // ---------------------------------------------------------------
    // receiver: own stall pattern, plus one long hold-off on request
    // ---------------------------------------------------------------
    always
    begin
        @(negedge clk);
        if (hold_off_req)
        begin
            out_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clk);
            hold_off_req = 1'b0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                rx_mode    = rx_mode_t'($urandom_range(0, 2));
                stall_left = $urandom_range(20, 150);
            end
            stall_left--;
            case (rx_mode)
                RX_STEADY: out_ready <= 1'b1;
                RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
                default:   out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_mix.size() == 0)
            begin
                $error("result transaction with none expected: duty %0d active_count %0d",
                       duty, active_count);
                errors++;
            end
            else
            begin
                mix_seen = expected_mix.pop_front();
                if (duty !== mix_seen.duty)
                begin
                    $error("duty: expected %0d, got %0d", mix_seen.duty, duty);
                    errors++;
                end
                if (active_count !== mix_seen.active)
                begin
                    $error("active_count: expected %0d, got %0d", mix_seen.active, active_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_reset_state;
        send_item(FUNC_TICK, '0, '0, '0);   // silent tick
        send_item(FUNC_TICK, '1, '0, '0);   // all voices at phase zero
    endtask

    task automatic test_step_loads;
        send_item(FUNC_LOAD, '0, 4'd12, 13'd8190);
        send_item(FUNC_LOAD, '1, 4'd0, 13'd1);
        // voices past the last one are ignored
        send_item(FUNC_LOAD, '0, 4'd13, 13'd8190);
        send_item(FUNC_LOAD, '0, 4'd15, 13'd8190);
        send_item(FUNC_TICK, '1, '0, '0);
    endtask

    task automatic test_phase_limit;
        // voice 0 lands exactly on the table size, voice 12 overshoots: both go to 0
        send_item(FUNC_LOAD, '0, 4'd0, 13'd8190);
        send_item(FUNC_TICK, 13'h1001, '0, '0);
        send_item(FUNC_TICK, 13'h1001, 4'd15, 13'd8190);
    endtask

    task automatic test_mask_patterns;
        send_item(FUNC_LOAD, '0, 4'd5, 13'd2048);
        send_item(FUNC_LOAD, '0, 4'd6, 13'd4095);
        send_item(FUNC_LOAD, '0, 4'd7, 13'd6143);
        send_item(FUNC_LOAD, '0, 4'd1, 13'd4096);
        send_item(FUNC_TICK, 13'h0AAA, '0, '0);
        send_item(FUNC_TICK, 13'h1555, '0, '0);
        send_item(FUNC_TICK, 13'h00E0, '0, '0);
        send_item(FUNC_TICK, 13'h1000, '0, '0);
        send_item(FUNC_TICK, 13'h0001, '0, '0);
    endtask

    task automatic test_random_mix;
        logic [MASK_W-1:0] mask;
        logic [SEL_W-1:0]  sel;
        logic [INC_W-1:0]  inc;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a stretch in the middle runs without sender gaps
            gaps_on = !(i >= 200 && i < 300);
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 15) == 0)
                    sel = SEL_W'($urandom_range(NUM_NOTES, 15));
                else
                    sel = SEL_W'($urandom_range(0, NUM_NOTES - 1));
                case ($urandom_range(0, 3))
                    0:       inc = INC_W'($urandom_range(0, 15));
                    1:       inc = INC_W'($urandom_range(8180, 8190));
                    2:       inc = 13'd1 << $urandom_range(0, 12);
                    default: inc = INC_W'($urandom_range(0, 8190));
                endcase
                send_item(FUNC_LOAD, MASK_W'($urandom), sel, inc);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       mask = '0;
                    1:       mask = '1;
                    2:       mask = 13'd1 << $urandom_range(0, NUM_NOTES - 1);
                    default: mask = MASK_W'($urandom);
                endcase
                send_item(FUNC_TICK, mask, SEL_W'($urandom), INC_W'($urandom_range(0, 8190)));
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure;
        // receiver holds off while ticks keep coming, so the input stalls
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_item(FUNC_TICK, MASK_W'($urandom), SEL_W'($urandom),
                      INC_W'($urandom_range(0, 8190)));
        gaps_on = 1'b1;
    endtask

    initial
    begin
        errors       = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        stall_left   = 0;
        rx_mode      = RX_STEADY;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_TICK;
        note_mask    = '0;
        note_select  = '0;
        increment    = '0;
        out_ready    = 1'b0;
        for (int i = 0; i < TABLE_SIZE; i++)
            sine_table[i] = sine_table_entry(i);
        for (int n = 0; n < NUM_NOTES; n++)
        begin
            voice_phase[n] = '0;
            voice_step[n]  = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_step_loads();
        test_phase_limit();
        test_mask_patterns();
        test_random_mix();
        test_backpressure();

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
